### rtl/assert_macros.svh
// Assertion macros used by the button classifier RTL (bpc_lane).
// No dependencies; bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked check, masked while reset is asserted
`define BPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked check, also evaluated during reset
`define BPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BPC_ASSERT(lbl, clk, rstn, prop, msg)
`define BPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/bpc_pkg.sv
// Package for the button press classifier: press codes, field widths,
// register map and the lane status struct. No dependencies.
package bpc_pkg;

  // Press codes, two bits per button
  localparam logic [1:0] CODE_IDLE   = 2'd0;
  localparam logic [1:0] CODE_ACTIVE = 2'd1;
  localparam logic [1:0] CODE_TOGGLE = 2'd2;
  localparam logic [1:0] CODE_MODE   = 2'd3;

  // Fixed field widths
  localparam int LEVEL_W  = 4;
  localparam int TIME_W   = 32;
  localparam int HOLD_W   = 16;
  localparam int CODES_W  = 8;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  // Register map
  localparam int CFG_ADDR_W = 3;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd2500;
  localparam logic REG_HOLD = 1'b0;  // word index bit of hold_threshold_ms

  // What one lane reports to the merge stage for the transaction
  typedef struct packed {
    logic [1:0] code;      // code after this scan
    logic       level;     // level in this scan
    logic       changed;   // level differs from previous scan
    logic       mode_hit;  // hold reached threshold in this scan
  } lane_stat_t;

endpackage

### rtl/button_press_classifier_unit.sv
// Top level of the button press classifier: config register, button lanes
// and merge stage. Depends on bpc_pkg, bpc_lane, bpc_merge.
//
//  channel  | ports      | payload
//  ---------+------------+-----------------------------------------------
//  in       | in_t*      | pressed_bits[3:0], now_ms[35:4]
//  out      | out_t*     | press_codes[7:0], any_pressed[8], report_due[9]
//  cfg      | cfg_p*     | hold_threshold_ms at byte address 0
//
// A new transaction is accepted every cycle while in_tready is high, all
// lanes updating in parallel with one 32-bit subtract and compare per lane.
// The result appears in the cycle after acceptance in a single output register.
// in_tready drops only while that register is full and out_tready is low.
// Synchronous reset clears levels, armed bits, codes and restores 2500 ms.
module button_press_classifier_unit import bpc_pkg::*; #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pressed_bits[3:0], now_ms[35:4], zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // press_codes[7:0], any_pressed, report_due
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic [HOLD_W-1:0] hold_r;
  logic              cfg_wr;
  logic              in_fire;
  logic [LEVEL_W-1:0] pressed_bits;
  logic [TIME_W-1:0]  now_ms;
  lane_stat_t        stat [NUM_BUTTONS];

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_HOLD);
  assign cfg_prdata = (cfg_paddr[2] == REG_HOLD) ? {16'd0, hold_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= HOLD_RESET;
    end else if (cfg_wr) begin
      hold_r <= cfg_pwdata[HOLD_W-1:0];
    end
  end

  // Input unpack
  assign pressed_bits = in_tdata[LEVEL_W-1:0];
  assign now_ms       = in_tdata[LEVEL_W +: TIME_W];
  assign in_fire      = in_tvalid && in_tready;

  // Button lanes; buttons beyond the input field read as released
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic lvl;
    if (i < LEVEL_W) begin : g_in
      assign lvl = pressed_bits[i];
    end else begin : g_none
      assign lvl = 1'b0;
    end
    bpc_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (in_fire),
      .level   (lvl),
      .now_ms  (now_ms),
      .hold_ms (hold_r),
      .stat    (stat[i])
    );
  end

  bpc_merge #(.NUM_BUTTONS(NUM_BUTTONS)) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .in_fire    (in_fire),
    .in_ready   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/bpc_lane.sv
// One button lane: last level, press start time, armed bit and code.
// Depends on bpc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bpc_lane import bpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              level,
  input  logic [TIME_W-1:0] now_ms,
  input  logic [HOLD_W-1:0] hold_ms,
  output lane_stat_t        stat
);

  logic              last_r, last_nxt;
  logic              armed_r, armed_nxt;
  logic [1:0]        code_r, code_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              changed;
  logic              hold_hit;

  // Elapsed time wraps modulo 2^32
  assign elapsed  = now_ms - start_r;
  assign changed  = level != last_r;
  assign hold_hit = level && !changed && armed_r && (elapsed >= {16'd0, hold_ms});

  // Per-button update
  always_comb begin
    last_nxt  = level;
    armed_nxt = armed_r;
    code_nxt  = code_r;
    start_nxt = start_r;
    if (level && changed) begin
      start_nxt = now_ms;
      armed_nxt = 1'b1;
      code_nxt  = CODE_ACTIVE;
    end else if (level && armed_r) begin
      if (hold_hit) begin
        code_nxt  = CODE_MODE;
        armed_nxt = 1'b0;
      end
    end else if (!level && changed) begin
      code_nxt  = CODE_TOGGLE;
      armed_nxt = 1'b0;
    end else if (code_r != CODE_IDLE) begin
      code_nxt = CODE_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= 1'b0;
      armed_r <= 1'b0;
      code_r  <= CODE_IDLE;
    end else if (advance) begin
      last_r  <= last_nxt;
      armed_r <= armed_nxt;
      code_r  <= code_nxt;
    end
  end

  // Start time only matters while armed
  always_ff @(posedge clk) begin
    if (advance) begin
      start_r <= start_nxt;
    end
  end

  assign stat.code     = code_nxt;
  assign stat.level    = level;
  assign stat.changed  = changed;
  assign stat.mode_hit = hold_hit;

  // Lane invariants
  `BPC_ASSERT(a_mode_disarmed, clk, rst_n, (code_r == CODE_MODE) |-> !armed_r, "mode code while armed")
  `BPC_ASSERT(a_armed_held, clk, rst_n, armed_r |-> last_r, "armed button not held")
  `BPC_ASSERT(a_toggle_released, clk, rst_n, (code_r == CODE_TOGGLE) |-> (!last_r && !armed_r), "toggle code on held button")

endmodule

### rtl/bpc_merge.sv
// Merge stage: packs lane codes, ORs the flags and holds the result
// register for the output channel. Depends on bpc_pkg.
module bpc_merge import bpc_pkg::*; #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lane_stat_t             stat [NUM_BUTTONS],
  input  logic                   in_fire,
  output logic                   in_ready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int CODE_LANES = (NUM_BUTTONS < 4) ? NUM_BUTTONS : 4;

  logic [CODES_W-1:0] codes;
  logic               any_hit;
  logic               report;
  logic               valid_r, valid_nxt;
  logic [CODES_W-1:0] codes_r;
  logic               any_r;
  logic               report_r;

  // Combine lane results
  always_comb begin
    codes   = '0;
    any_hit = 1'b0;
    report  = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      any_hit = any_hit | stat[i].level;
      report  = report | stat[i].changed | stat[i].mode_hit;
    end
    for (int i = 0; i < CODE_LANES; i++) begin
      codes[2*i +: 2] = stat[i].code;
    end
  end

  // Result register; refills in the cycle it drains
  assign in_ready  = !valid_r || out_tready;
  assign valid_nxt = in_fire ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      codes_r  <= codes;
      any_r    <= any_hit;
      report_r <= report;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, report_r, any_r, codes_r};

endmodule
